### hdl/ctr_pkg.sv
// Shared types and constants for the console terminal registers.
package ctr_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RX    = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	localparam logic [17:0] ADDR_RXS = 18'o777560;
	localparam logic [17:0] ADDR_RXB = 18'o777562;
	localparam logic [17:0] ADDR_TXS = 18'o777564;
	localparam logic [17:0] ADDR_TXB = 18'o777566;

	localparam int BIT_DONE = 7;
	localparam int BIT_IE   = 6;

	localparam int          DELAY_W   = 6;
	localparam logic [5:0]  DELAY_MAX = 6'd63;

	localparam logic [7:0] RX_XLAT_A_IN  = 8'd42;
	localparam logic [7:0] RX_XLAT_A_OUT = 8'd4;
	localparam logic [7:0] RX_XLAT_B_IN  = 8'd19;
	localparam logic [7:0] RX_XLAT_B_OUT = 8'o034;

	typedef struct packed {
		op_t         op;
		logic [17:0] bus_address;
		logic [15:0] write_data;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        tx_valid;
		logic [6:0]  tx_char;
		logic        rx_interrupt;
		logic        tx_interrupt;
		logic        bus_error;
	} result_t;

endpackage

### hdl/ctr_cmd_if.sv
// Input channel: bus read, bus write, received byte or poll tick.
interface ctr_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [17:0] bus_address;
	logic [15:0] write_data;
	logic [7:0]  rx_byte;

	modport source (output valid, op, bus_address, write_data, rx_byte, input ready);
	modport sink (input valid, op, bus_address, write_data, rx_byte, output ready);
endinterface

### hdl/ctr_rsp_if.sv
// Result channel: read data, transmitted character, interrupts and bus error.
interface ctr_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        tx_valid;
	logic [6:0]  tx_char;
	logic        rx_interrupt;
	logic        tx_interrupt;
	logic        bus_error;

	modport source (output valid, read_data, tx_valid, tx_char, rx_interrupt, tx_interrupt,
		bus_error, input ready);
	modport sink (input valid, read_data, tx_valid, tx_char, rx_interrupt, tx_interrupt,
		bus_error, output ready);
endinterface

### hdl/ctr_regs.sv
// Device registers: address decode, receive translation and transmit delay.
module ctr_regs #(
	parameter int TX_DELAY_TICKS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ctr_pkg::item_t   item,
	output ctr_pkg::result_t res
);

	localparam logic [ctr_pkg::DELAY_W-1:0] DELAY_LIMIT = ctr_pkg::DELAY_W'(TX_DELAY_TICKS);

	logic                        rx_done_q, rx_ie_q, tx_done_q, tx_ie_q;
	logic [7:0]                  rx_buffer_q;
	logic [6:0]                  tx_buffer_q;
	logic [ctr_pkg::DELAY_W-1:0] delay_q;

	logic                        rx_done_d, rx_ie_d, tx_done_d, tx_ie_d;
	logic [7:0]                  rx_buffer_d;
	logic [6:0]                  tx_buffer_d;
	logic [ctr_pkg::DELAY_W-1:0] delay_d;
	logic [15:0]                 rx_status, tx_status;

	always_comb begin
		rx_status = '0;
		rx_status[ctr_pkg::BIT_DONE] = rx_done_q;
		rx_status[ctr_pkg::BIT_IE]   = rx_ie_q;
		tx_status = '0;
		tx_status[ctr_pkg::BIT_DONE] = tx_done_q;
		tx_status[ctr_pkg::BIT_IE]   = tx_ie_q;
	end

	always_comb begin
		res         = '0;
		rx_done_d   = rx_done_q;
		rx_ie_d     = rx_ie_q;
		tx_done_d   = tx_done_q;
		tx_ie_d     = tx_ie_q;
		rx_buffer_d = rx_buffer_q;
		tx_buffer_d = tx_buffer_q;
		delay_d     = delay_q;
		case (item.op)
			ctr_pkg::OP_READ: begin
				case (item.bus_address)
					ctr_pkg::ADDR_RXS: res.read_data = rx_status;
					ctr_pkg::ADDR_RXB: begin
						if (rx_done_q) begin
							rx_done_d      = 1'b0;
							res.read_data  = {8'd0, rx_buffer_q};
						end
					end
					ctr_pkg::ADDR_TXS: res.read_data = tx_status;
					ctr_pkg::ADDR_TXB: res.read_data = '0;
					default: res.bus_error = 1'b1;
				endcase
			end
			ctr_pkg::OP_WRITE: begin
				case (item.bus_address)
					ctr_pkg::ADDR_RXS: rx_ie_d = item.write_data[ctr_pkg::BIT_IE];
					ctr_pkg::ADDR_TXS: tx_ie_d = item.write_data[ctr_pkg::BIT_IE];
					ctr_pkg::ADDR_TXB: begin
						tx_buffer_d = item.write_data[6:0];
						tx_done_d   = 1'b0;
						delay_d     = '0;
					end
					default: res.bus_error = 1'b1;
				endcase
			end
			ctr_pkg::OP_RX: begin
				if (item.rx_byte == ctr_pkg::RX_XLAT_A_IN) begin
					rx_buffer_d = ctr_pkg::RX_XLAT_A_OUT;
				end else if (item.rx_byte == ctr_pkg::RX_XLAT_B_IN) begin
					rx_buffer_d = ctr_pkg::RX_XLAT_B_OUT;
				end else begin
					rx_buffer_d = item.rx_byte;
				end
				rx_done_d        = 1'b1;
				res.rx_interrupt = rx_ie_q;
			end
			ctr_pkg::OP_TICK: begin
				if (!tx_done_q) begin
					if (delay_q != ctr_pkg::DELAY_MAX) begin
						delay_d = delay_q + 1'b1;
					end
					if (delay_d > DELAY_LIMIT) begin
						res.tx_valid     = 1'b1;
						res.tx_char      = tx_buffer_q;
						tx_done_d        = 1'b1;
						res.tx_interrupt = tx_ie_q;
					end
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_done_q   <= 1'b0;
			rx_ie_q     <= 1'b0;
			tx_done_q   <= 1'b1;
			tx_ie_q     <= 1'b0;
			rx_buffer_q <= '0;
			tx_buffer_q <= '0;
			delay_q     <= '0;
		end else if (step) begin
			rx_done_q   <= rx_done_d;
			rx_ie_q     <= rx_ie_d;
			tx_done_q   <= tx_done_d;
			tx_ie_q     <= tx_ie_d;
			rx_buffer_q <= rx_buffer_d;
			tx_buffer_q <= tx_buffer_d;
			delay_q     <= delay_d;
		end
	end

	a_tx_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.tx_valid |=> tx_done_q)
		else $error("transmit did not set ready");

	a_rx_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.op == ctr_pkg::OP_RX |=> rx_done_q)
		else $error("received byte did not set done");

	a_berr_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.bus_error |=> $stable(rx_done_q) && $stable(rx_ie_q) && $stable(tx_done_q)
			&& $stable(tx_ie_q) && $stable(tx_buffer_q) && $stable(delay_q))
		else $error("bus error transaction changed state");

	a_tx_needs_delay: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.tx_valid |-> !tx_done_q && delay_d > DELAY_LIMIT)
		else $error("transmit before delay elapsed");

endmodule

### hdl/console_terminal_registers.sv
// Console terminal registers: input register, register update and result register.
// The input register holds the accepted transaction; the result register then loads the update's result.
// Throughput: one transaction per cycle while the result is not stalled; the register update is a single pass.
// A stalled result is held; the input register then accepts a new transaction only while it is empty.
// arst_n clears valid flags and device state: receiver status 0, transmitter status 0x80 (ready), count 0.
module console_terminal_registers #(
	parameter int TX_DELAY_TICKS = 32
) (
	input logic       clk,
	input logic       arst_n,
	ctr_cmd_if.sink   cmd,
	ctr_rsp_if.source rsp
);

	ctr_pkg::item_t   item_s1;
	logic             valid_s1;
	ctr_pkg::result_t result_s2;
	logic             valid_s2;
	ctr_pkg::result_t res;
	logic             advance;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || !valid_s2 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (!valid_s2 || rsp.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.op          <= ctr_pkg::op_t'(cmd.op);
			item_s1.bus_address <= cmd.bus_address;
			item_s1.write_data  <= cmd.write_data;
			item_s1.rx_byte     <= cmd.rx_byte;
		end
		if (advance) begin
			result_s2 <= res;
		end
	end

	ctr_regs #(
		.TX_DELAY_TICKS(TX_DELAY_TICKS)
	) u_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.res   (res)
	);

	assign rsp.valid        = valid_s2;
	assign rsp.read_data    = result_s2.read_data;
	assign rsp.tx_valid     = result_s2.tx_valid;
	assign rsp.tx_char      = result_s2.tx_char;
	assign rsp.rx_interrupt = result_s2.rx_interrupt;
	assign rsp.tx_interrupt = result_s2.tx_interrupt;
	assign rsp.bus_error    = result_s2.bus_error;

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled transaction");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp.ready |=> valid_s2 && $stable(result_s2))
		else $error("result overwritten while stalled");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced transaction not presented");

endmodule

### tb/sv/console_terminal_registers_test.sv
// Self-checking testbench for the console terminal registers: directed table, then random traffic.
module console_terminal_registers_test;
	import ctr_pkg::*;

	localparam int TX_DELAY      = 32;
	localparam int RANDOM_ITEMS  = 740;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AT       = 300;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 10;

	typedef struct {
		item_t   it;
		int      rep;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ctr_cmd_if cmd_ch();
	ctr_rsp_if rsp_ch();

	console_terminal_registers #(.TX_DELAY_TICKS(TX_DELAY)) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted register state
	logic [15:0]        rcsr;
	logic [7:0]         rbuf;
	logic [15:0]        xcsr;
	logic [7:0]         xbuf;
	logic [DELAY_W-1:0] xmit_delay;

	result_t  pending_results[$];
	dir_row_t directed_tab[$];
	int       accepted_items = 0;
	int       mismatches = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	int       stall_phase = 0;
	int       stall_mode = 0;
	bit       held = 1'b0;
	int       random_base;
	int       scenario;
	int       n;
	item_t    cur;
	result_t  seen;
	result_t  wanted;

	function automatic result_t terminal_step(input item_t it);
		result_t r;
		r = '0;
		case (it.op)
			OP_READ: begin
				case (it.bus_address)
					ADDR_RXS: r.read_data = rcsr;
					ADDR_RXB: begin
						if (rcsr[BIT_DONE]) begin
							rcsr[BIT_DONE] = 1'b0;
							rcsr[0] = 1'b0;
							r.read_data = {8'h00, rbuf};
						end
					end
					ADDR_TXS: r.read_data = xcsr;
					ADDR_TXB: r.read_data = '0;
					default: r.bus_error = 1'b1;
				endcase
			end
			OP_WRITE: begin
				case (it.bus_address)
					ADDR_RXS: rcsr[BIT_IE] = it.write_data[BIT_IE];
					ADDR_TXS: xcsr[BIT_IE] = it.write_data[BIT_IE];
					ADDR_TXB: begin
						xbuf = it.write_data[7:0];
						xcsr[BIT_DONE] = 1'b0;
						xmit_delay = '0;
					end
					default: r.bus_error = 1'b1;
				endcase
			end
			OP_RX: begin
				if (it.rx_byte == RX_XLAT_A_IN)
					rbuf = RX_XLAT_A_OUT;
				else if (it.rx_byte == RX_XLAT_B_IN)
					rbuf = RX_XLAT_B_OUT;
				else
					rbuf = it.rx_byte;
				rcsr[BIT_DONE] = 1'b1;
				r.rx_interrupt = rcsr[BIT_IE];
			end
			default: begin
				if (!xcsr[BIT_DONE]) begin
					if (xmit_delay != DELAY_MAX)
						xmit_delay = xmit_delay + 1'b1;
					if (xmit_delay > TX_DELAY) begin
						r.tx_valid = 1'b1;
						r.tx_char = xbuf[6:0];
						xcsr[BIT_DONE] = 1'b1;
						r.tx_interrupt = xcsr[BIT_IE];
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic result_t outcome(input logic [15:0] rd, input logic txv,
		input logic [6:0] txc, input logic rxi, input logic txi, input logic berr);
		return {rd, txv, txc, rxi, txi, berr};
	endfunction

	function automatic dir_row_t row(input op_t op, input logic [17:0] addr,
		input logic [15:0] data, input logic [7:0] rxb, input int rep, input bit typed,
		input result_t want);
		dir_row_t d;
		d.it = {op, addr, data, rxb};
		d.rep = rep;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	function automatic logic [17:0] pick_address();
		logic [17:0] decoded[4];
		decoded = '{ADDR_RXS, ADDR_RXB, ADDR_TXS, ADDR_TXB};
		if ($urandom_range(0, 9) < 8)
			return decoded[$urandom_range(0, 3)];
		return 18'($urandom);
	endfunction

	function automatic item_t rand_item(input op_t op);
		item_t it;
		it.op = op;
		it.bus_address = pick_address();
		it.write_data = 16'($urandom);
		case ($urandom_range(0, 5))
			0: it.rx_byte = RX_XLAT_A_IN;
			1: it.rx_byte = RX_XLAT_B_IN;
			default: it.rx_byte = 8'($urandom);
		endcase
		return it;
	endfunction

	task automatic send(input item_t it, input bit typed, input result_t want);
		result_t p;
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= it.op;
		cmd_ch.bus_address <= it.bus_address;
		cmd_ch.write_data <= it.write_data;
		cmd_ch.rx_byte <= it.rx_byte;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		p = terminal_step(it);
		pending_results.push_back(typed ? want : p);
		accepted_items++;
		@(negedge clk);
		if (burst_left == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end else begin
			burst_left--;
		end
	endtask

	// receiver: changing stall patterns, plus one long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && accepted_items >= HOLD_AT) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end else begin
				stall_phase++;
				if (stall_phase % 50 == 0)
					stall_mode = $urandom_range(0, 3);
				case (stall_mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready <= (stall_phase[2:0] != 3'd5);
					default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen = {rsp_ch.read_data, rsp_ch.tx_valid, rsp_ch.tx_char, rsp_ch.rx_interrupt,
				rsp_ch.tx_interrupt, rsp_ch.bus_error};
			if (pending_results.size() == 0) begin
				$display("%0t unexpected transaction: %h", $time, seen);
				mismatches++;
			end else begin
				wanted = pending_results.pop_front();
				if (seen.read_data !== wanted.read_data) begin
					$display("%0t read_data expected %h got %h", $time, wanted.read_data,
						seen.read_data);
					mismatches++;
				end
				if (seen.tx_valid !== wanted.tx_valid) begin
					$display("%0t tx_valid expected %b got %b", $time, wanted.tx_valid,
						seen.tx_valid);
					mismatches++;
				end
				if (seen.tx_char !== wanted.tx_char) begin
					$display("%0t tx_char expected %h got %h", $time, wanted.tx_char,
						seen.tx_char);
					mismatches++;
				end
				if (seen.rx_interrupt !== wanted.rx_interrupt) begin
					$display("%0t rx_interrupt expected %b got %b", $time, wanted.rx_interrupt,
						seen.rx_interrupt);
					mismatches++;
				end
				if (seen.tx_interrupt !== wanted.tx_interrupt) begin
					$display("%0t tx_interrupt expected %b got %b", $time, wanted.tx_interrupt,
						seen.tx_interrupt);
					mismatches++;
				end
				if (seen.bus_error !== wanted.bus_error) begin
					$display("%0t bus_error expected %b got %b", $time, wanted.bus_error,
						seen.bus_error);
					mismatches++;
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either channel
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("console_terminal_registers regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_READ;
		cmd_ch.bus_address = '0;
		cmd_ch.write_data = '0;
		cmd_ch.rx_byte = '0;
		rcsr = '0;
		rbuf = '0;
		xcsr = 16'h0080;
		xbuf = '0;
		xmit_delay = '0;

		directed_tab.push_back(row(OP_READ, ADDR_RXS, 16'hffff, 8'hff, 1, 1, '0));
		directed_tab.push_back(row(OP_READ, ADDR_TXS, 16'h0, 8'h0, 1, 1,
			outcome(16'h0080, 0, 0, 0, 0, 0)));
		directed_tab.push_back(row(OP_READ, ADDR_RXB, 16'h0, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_READ, ADDR_TXB, 16'h0, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_READ, 18'h0, 16'h0, 8'h0, 1, 1,
			outcome(0, 0, 0, 0, 0, 1)));
		directed_tab.push_back(row(OP_READ, 18'h3ffff, 16'h0, 8'h0, 1, 1,
			outcome(0, 0, 0, 0, 0, 1)));
		// receiver buffer is not decoded for writes
		directed_tab.push_back(row(OP_WRITE, ADDR_RXB, 16'hffff, 8'h0, 1, 1,
			outcome(0, 0, 0, 0, 0, 1)));
		directed_tab.push_back(row(OP_WRITE, 18'h3ffff, 16'h0, 8'h0, 1, 1,
			outcome(0, 0, 0, 0, 0, 1)));
		directed_tab.push_back(row(OP_WRITE, ADDR_RXS, 16'hffff, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_WRITE, ADDR_TXS, 16'hffbf, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_WRITE, ADDR_TXS, 16'h0040, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_READ, ADDR_RXS, 16'h0, 8'h0, 1, 1,
			outcome(16'h0040, 0, 0, 0, 0, 0)));
		directed_tab.push_back(row(OP_READ, ADDR_TXS, 16'h0, 8'h0, 1, 1,
			outcome(16'h00c0, 0, 0, 0, 0, 0)));
		directed_tab.push_back(row(OP_RX, ADDR_RXS, 16'h0, RX_XLAT_A_IN, 1, 1,
			outcome(0, 0, 0, 1, 0, 0)));
		directed_tab.push_back(row(OP_READ, ADDR_RXS, 16'h0, 8'h0, 1, 1,
			outcome(16'h00c0, 0, 0, 0, 0, 0)));
		directed_tab.push_back(row(OP_READ, ADDR_RXB, 16'h0, 8'h0, 1, 1,
			outcome({8'h00, RX_XLAT_A_OUT}, 0, 0, 0, 0, 0)));
		directed_tab.push_back(row(OP_RX, 18'h0, 16'h0, RX_XLAT_B_IN, 1, 1,
			outcome(0, 0, 0, 1, 0, 0)));
		directed_tab.push_back(row(OP_READ, ADDR_RXB, 16'h0, 8'h0, 1, 1,
			outcome({8'h00, RX_XLAT_B_OUT}, 0, 0, 0, 0, 0)));
		directed_tab.push_back(row(OP_RX, 18'h0, 16'h0, 8'hff, 1, 1,
			outcome(0, 0, 0, 1, 0, 0)));
		directed_tab.push_back(row(OP_READ, ADDR_RXB, 16'h0, 8'h0, 1, 1,
			outcome(16'h00ff, 0, 0, 0, 0, 0)));
		directed_tab.push_back(row(OP_READ, ADDR_RXB, 16'h0, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_WRITE, ADDR_RXS, 16'h0, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_RX, 18'h0, 16'h0, 8'h00, 1, 1, '0));
		directed_tab.push_back(row(OP_WRITE, ADDR_TXB, 16'hffff, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_READ, ADDR_TXS, 16'h0, 8'h0, 1, 1,
			outcome(16'h0040, 0, 0, 0, 0, 0)));
		directed_tab.push_back(row(OP_TICK, 18'h0, 16'h0, 8'h0, TX_DELAY, 0, '0));
		directed_tab.push_back(row(OP_TICK, 18'h0, 16'h0, 8'h0, 1, 1,
			outcome(0, 1, 7'h7f, 0, 1, 0)));
		directed_tab.push_back(row(OP_TICK, 18'h0, 16'h0, 8'h0, 1, 1, '0));
		// interrupt off, rewrite of the buffer mid-count restarts the delay
		directed_tab.push_back(row(OP_WRITE, ADDR_TXS, 16'h0, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_WRITE, ADDR_TXB, 16'h0155, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_TICK, 18'h0, 16'h0, 8'h0, 10, 0, '0));
		directed_tab.push_back(row(OP_WRITE, ADDR_TXB, 16'h00d5, 8'h0, 1, 1, '0));
		directed_tab.push_back(row(OP_TICK, 18'h0, 16'h0, 8'h0, TX_DELAY, 0, '0));
		directed_tab.push_back(row(OP_TICK, 18'h0, 16'h0, 8'h0, 1, 1,
			outcome(0, 1, 7'h55, 0, 0, 0)));

		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_tab[i])
			repeat (directed_tab[i].rep)
				send(directed_tab[i].it, directed_tab[i].typed, directed_tab[i].want);

		random_base = accepted_items;
		while (accepted_items - random_base < RANDOM_ITEMS) begin
			scenario = $urandom_range(0, 9);
			if (scenario < 4) begin
				cur = rand_item(OP_WRITE);
				cur.bus_address = ADDR_TXB;
				send(cur, 0, '0);
				n = $urandom_range(30, 40);
				repeat (n) begin
					if ($urandom_range(0, 4) != 0)
						cur = rand_item(OP_TICK);
					else
						cur = rand_item(op_t'($urandom_range(0, 3)));
					send(cur, 0, '0);
				end
			end else if (scenario < 7) begin
				if ($urandom_range(0, 2) == 0) begin
					cur = rand_item(OP_WRITE);
					cur.bus_address = ADDR_RXS;
					send(cur, 0, '0);
				end
				send(rand_item(OP_RX), 0, '0);
				if ($urandom_range(0, 1) == 0) begin
					cur = rand_item(OP_READ);
					cur.bus_address = ADDR_RXS;
					send(cur, 0, '0);
				end
				repeat ($urandom_range(1, 2)) begin
					cur = rand_item(OP_READ);
					cur.bus_address = ADDR_RXB;
					send(cur, 0, '0);
				end
			end else begin
				repeat ($urandom_range(5, 15))
					send(rand_item(op_t'($urandom_range(0, 3))), 0, '0);
			end
		end
		cmd_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("console_terminal_registers regression: pass");
		else
			$display("console_terminal_registers regression: fail");
		$finish;
	end

endmodule
